### hdl/wps_pkg.sv
// shared types, constants and tag lookup for the wav pcm16 mono stream parser
// no dependencies; imported by the front parser, the result queue and the top level
package wps_pkg;

  // header geometry
  localparam int unsigned HEADER_LEN  = 44;
  localparam int unsigned POS_W       = 6;
  localparam int unsigned QUEUE_DEPTH = 4;

  // byte offsets of header fields
  localparam logic [POS_W-1:0] OFF_WAVE         = 6'd8;
  localparam logic [POS_W-1:0] OFF_FMT          = 6'd12;
  localparam logic [POS_W-1:0] OFF_FMT_END      = 6'd16;
  localparam logic [POS_W-1:0] OFF_RIFF_END     = 6'd4;
  localparam logic [POS_W-1:0] OFF_FORMAT       = 6'd20;
  localparam logic [POS_W-1:0] OFF_CHANNELS     = 6'd22;
  localparam logic [POS_W-1:0] OFF_RATE         = 6'd24;
  localparam logic [POS_W-1:0] OFF_BPS          = 6'd28;
  localparam logic [POS_W-1:0] OFF_ALIGN        = 6'd32;
  localparam logic [POS_W-1:0] OFF_DEPTH        = 6'd34;
  localparam logic [POS_W-1:0] OFF_PRODUCT      = 6'd36;
  localparam logic [POS_W-1:0] OFF_SAMPLE_BYTES = 6'd40;
  localparam logic [POS_W-1:0] OFF_LAST         = 6'(HEADER_LEN - 1);

  // expected field values
  localparam logic [15:0] PCM_FORMAT = 16'd1;
  localparam logic [15:0] MONO       = 16'd1;
  localparam logic [15:0] DEPTH_16   = 16'd16;

  // header verdict codes
  typedef enum logic [3:0] {
    ST_OK       = 4'd0,
    ST_RIFF     = 4'd1,
    ST_WAVE     = 4'd2,
    ST_FMT      = 4'd3,
    ST_PCM      = 4'd4,
    ST_MONO     = 4'd5,
    ST_BYTERATE = 4'd6,
    ST_ALIGN    = 4'd7,
    ST_DEPTH    = 4'd8
  } status_t;

  typedef enum logic {
    KIND_VERDICT = 1'b0,
    KIND_SAMPLE  = 1'b1
  } kind_t;

  // one result item
  typedef struct packed {
    kind_t              kind;
    status_t            status;
    logic signed [15:0] sample;
    logic               last;
  } result_t;

  // expected byte of the riff, wave and fmt tags at a header position
  function automatic logic [7:0] tag_byte(input logic [POS_W-1:0] pos);
    logic [7:0] b;
    unique case (pos)
      6'd0:    b = 8'h52;
      6'd1:    b = 8'h49;
      6'd2:    b = 8'h46;
      6'd3:    b = 8'h46;
      6'd8:    b = 8'h57;
      6'd9:    b = 8'h41;
      6'd10:   b = 8'h56;
      6'd11:   b = 8'h45;
      6'd12:   b = 8'h66;
      6'd13:   b = 8'h6D;
      6'd14:   b = 8'h74;
      6'd15:   b = 8'h20;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

### hdl/wps_front.sv
// front part: captures the header, checks it and pairs audio bytes into samples
// depends on wps_pkg; emits at most one result item per accepted byte
module wps_front (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  input  logic [7:0]       data_byte,
  input  logic             start_of_file,
  output logic             res_valid,
  output wps_pkg::result_t res
);
  import wps_pkg::*;

  typedef enum logic [2:0] {
    PH_HEADER = 3'b001,
    PH_DATA   = 3'b010,
    PH_IDLE   = 3'b100
  } phase_t;

  phase_t             phase, phase_next, cur_phase;
  logic [POS_W-1:0]   position, position_next, cur_pos;
  logic [2:0]         magic_ok, magic_ok_next, cur_magic;
  logic               byte_half, byte_half_next;
  logic [15:0]        fmt_code, fmt_code_next;
  logic [15:0]        channels, channels_next;
  logic [31:0]        rate, rate_next;
  logic [31:0]        bytes_per_sec, bytes_per_sec_next;
  logic [15:0]        align, align_next;
  logic [15:0]        depth, depth_next;
  logic [28:0]        expected_rate, expected_rate_next;
  logic [30:0]        samples_left, samples_left_next, samples_dec;
  logic [7:0]         low_byte, low_byte_next;
  logic [47:0]        product;
  logic               tag_bad;
  status_t            verdict;

  // rate times depth, registered once both fields are complete
  assign product = rate * depth;

  // restart mark acts as a reset of the parse state for this byte
  always_comb begin
    cur_phase = start_of_file ? PH_HEADER : phase;
    cur_pos   = start_of_file ? '0 : position;
    cur_magic = start_of_file ? 3'b111 : magic_ok;
  end

  assign tag_bad     = data_byte != tag_byte(cur_pos);
  assign samples_dec = samples_left - 31'd1;

  // first failing check in priority order
  always_comb begin
    if (!magic_ok[0])                                  verdict = ST_RIFF;
    else if (!magic_ok[1])                             verdict = ST_WAVE;
    else if (!magic_ok[2])                             verdict = ST_FMT;
    else if (fmt_code != PCM_FORMAT)                   verdict = ST_PCM;
    else if (channels != MONO)                         verdict = ST_MONO;
    else if (bytes_per_sec != {3'b000, expected_rate}) verdict = ST_BYTERATE;
    else if (align != {3'b000, depth[15:3]})           verdict = ST_ALIGN;
    else if (depth != DEPTH_16)                        verdict = ST_DEPTH;
    else                                               verdict = ST_OK;
  end

  // next state and result item
  always_comb begin
    phase_next         = phase;
    position_next      = position;
    magic_ok_next      = magic_ok;
    byte_half_next     = byte_half;
    fmt_code_next      = fmt_code;
    channels_next      = channels;
    rate_next          = rate;
    bytes_per_sec_next = bytes_per_sec;
    align_next         = align;
    depth_next         = depth;
    expected_rate_next = expected_rate;
    samples_left_next  = samples_left;
    low_byte_next      = low_byte;
    res_valid          = 1'b0;
    res                = '0;
    if (in_valid) begin
      phase_next     = cur_phase;
      position_next  = cur_pos;
      magic_ok_next  = cur_magic;
      byte_half_next = start_of_file ? 1'b0 : byte_half;
      unique case (cur_phase)
        PH_HEADER: begin
          // tag checks
          if (cur_pos < OFF_RIFF_END) begin
            if (tag_bad) magic_ok_next[0] = 1'b0;
          end else if (cur_pos >= OFF_WAVE && cur_pos < OFF_FMT) begin
            if (tag_bad) magic_ok_next[1] = 1'b0;
          end else if (cur_pos >= OFF_FMT && cur_pos < OFF_FMT_END) begin
            if (tag_bad) magic_ok_next[2] = 1'b0;
          end
          // little-endian field capture
          case (cur_pos)
            OFF_FORMAT:              fmt_code_next[7:0]        = data_byte;
            OFF_FORMAT + 6'd1:       fmt_code_next[15:8]       = data_byte;
            OFF_CHANNELS:            channels_next[7:0]        = data_byte;
            OFF_CHANNELS + 6'd1:     channels_next[15:8]       = data_byte;
            OFF_RATE:                rate_next[7:0]            = data_byte;
            OFF_RATE + 6'd1:         rate_next[15:8]           = data_byte;
            OFF_RATE + 6'd2:         rate_next[23:16]          = data_byte;
            OFF_RATE + 6'd3:         rate_next[31:24]          = data_byte;
            OFF_BPS:                 bytes_per_sec_next[7:0]   = data_byte;
            OFF_BPS + 6'd1:          bytes_per_sec_next[15:8]  = data_byte;
            OFF_BPS + 6'd2:          bytes_per_sec_next[23:16] = data_byte;
            OFF_BPS + 6'd3:          bytes_per_sec_next[31:24] = data_byte;
            OFF_ALIGN:               align_next[7:0]           = data_byte;
            OFF_ALIGN + 6'd1:        align_next[15:8]          = data_byte;
            OFF_DEPTH:               depth_next[7:0]           = data_byte;
            OFF_DEPTH + 6'd1:        depth_next[15:8]          = data_byte;
            OFF_PRODUCT:             expected_rate_next        = product[31:3];
            OFF_SAMPLE_BYTES:        samples_left_next         = {24'd0, data_byte[7:1]};
            OFF_SAMPLE_BYTES + 6'd1: samples_left_next         = samples_left
                                                                 | {16'd0, data_byte, 7'd0};
            OFF_SAMPLE_BYTES + 6'd2: samples_left_next         = samples_left
                                                                 | {8'd0, data_byte, 15'd0};
            OFF_SAMPLE_BYTES + 6'd3: samples_left_next         = samples_left
                                                                 | {data_byte, 23'd0};
            default: ;
          endcase
          // header end: verdict item
          if (cur_pos == OFF_LAST) begin
            res_valid      = 1'b1;
            res.kind       = KIND_VERDICT;
            res.status     = verdict;
            res.last       = (verdict == ST_OK) && (samples_left_next == '0);
            phase_next     = ((verdict == ST_OK) && (samples_left_next != '0)) ?
                             PH_DATA : PH_IDLE;
            position_next  = '0;
            byte_half_next = 1'b0;
          end else begin
            position_next = cur_pos + 6'd1;
          end
        end
        PH_DATA: begin
          if (!byte_half_next) begin
            low_byte_next  = data_byte;
            byte_half_next = 1'b1;
          end else begin
            byte_half_next    = 1'b0;
            samples_left_next = samples_dec;
            res_valid         = 1'b1;
            res.kind          = KIND_SAMPLE;
            res.status        = ST_OK;
            res.sample        = {data_byte, low_byte};
            res.last          = samples_dec == '0;
            if (samples_dec == '0) phase_next = PH_IDLE;
          end
        end
        default: ;
      endcase
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= PH_HEADER;
      position  <= '0;
      magic_ok  <= 3'b111;
      byte_half <= 1'b0;
    end else begin
      phase     <= phase_next;
      position  <= position_next;
      magic_ok  <= magic_ok_next;
      byte_half <= byte_half_next;
    end
  end

  // captured header fields and sample assembly
  always_ff @(posedge clk) begin
    fmt_code      <= fmt_code_next;
    channels      <= channels_next;
    rate          <= rate_next;
    bytes_per_sec <= bytes_per_sec_next;
    align         <= align_next;
    depth         <= depth_next;
    expected_rate <= expected_rate_next;
    samples_left  <= samples_left_next;
    low_byte      <= low_byte_next;
  end

endmodule

### hdl/wps_queue.sv
// back part: short result queue between the parser and the result channel
// depends on wps_pkg for the result item type
module wps_queue #(
  parameter int unsigned DEPTH = wps_pkg::QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr_en,
  input  wps_pkg::result_t wr_data,
  input  logic             rd_en,
  output wps_pkg::result_t rd_data,
  output logic             full,
  output logic             empty
);
  import wps_pkg::*;

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  result_t         entries [DEPTH];
  logic [AW-1:0]   wr_ptr, rd_ptr;
  logic [CW-1:0]   count, count_next;

  assign full    = count == CW'(DEPTH);
  assign empty   = count == '0;
  assign rd_data = entries[rd_ptr];

  // occupancy
  always_comb begin
    case ({wr_en, rd_en})
      2'b10:   count_next = count + 1'b1;
      2'b01:   count_next = count - 1'b1;
      default: count_next = count;
    endcase
  end

  // pointers
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      count <= count_next;
      if (wr_en) wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      if (rd_en) rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (wr_en) entries[wr_ptr] <= wr_data;
  end

endmodule

### hdl/wav_pcm16_mono_stream_parser_unit.sv
// Parses a WAV file given one byte per item and delivers a header verdict,
// then the file's signed 16-bit mono samples.
// Input channel: data_byte and start_of_file, taken when push is high and
// full is low. start_of_file marks byte 0 of a new file and restarts the parse.
// Result channel: result_kind, status, sample, last are valid while empty is
// low and are taken when pop is high.
// A byte that completes a result is written into the queue in the cycle it is accepted.
// Throughput: one byte per cycle; the front parser writes a queue of DEPTH
// result items, so input stalls (full) only once the queue has filled while
// pop is held low. The byte-rate product is formed and registered at header
// byte 36, ahead of the verdict at byte 43.
// Reset: the parser returns to header byte 0 and the queue empties; no
// clearing pass is needed.
// Verdicts come first, once per 44-byte header; a sample item carries last
// on the final sample, the ok verdict carries last when the file has none.
module wav_pcm16_mono_stream_parser_unit #(
  parameter int unsigned DEPTH = wps_pkg::QUEUE_DEPTH
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  output logic               full,
  input  logic [7:0]         data_byte,
  input  logic               start_of_file,
  output logic               empty,
  input  logic               pop,
  output logic               result_kind,
  output logic [3:0]         status,
  output logic signed [15:0] sample,
  output logic               last
);
  import wps_pkg::*;

  logic    in_valid;
  logic    res_valid;
  result_t res;
  result_t head;

  // input item accepted
  assign in_valid = push && !full;

  wps_front u_front (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .data_byte     (data_byte),
    .start_of_file (start_of_file),
    .res_valid     (res_valid),
    .res           (res)
  );

  wps_queue #(
    .DEPTH (DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (res_valid),
    .wr_data (res),
    .rd_en   (pop && !empty),
    .rd_data (head),
    .full    (full),
    .empty   (empty)
  );

  // result ports
  assign result_kind = head.kind;
  assign status      = head.status;
  assign sample      = head.sample;
  assign last        = head.last;

endmodule

### hdl/wps_checker.sv
// port-level checks of the stream parser's queue behavior over time
// no package dependency; attached to the top level by the bind below
module wps_checker (
  input logic        clk,
  input logic        rst,
  input logic        push,
  input logic        full,
  input logic        empty,
  input logic        pop,
  input logic        result_kind,
  input logic [3:0]  status,
  input logic [15:0] sample,
  input logic        last
);

  // reset leaves an empty queue that can take items
  a_reset_clear: assert property (@(posedge clk) rst |=> empty && !full)
    else $error("queue not empty or full after reset");

  // full and empty never together
  a_full_empty: assert property (@(posedge clk) disable iff (rst) !(full && empty))
    else $error("full and empty both asserted");

  // no result appears without an accepted item
  a_no_invent: assert property (@(posedge clk) disable iff (rst)
    empty && !(push && !full) |=> empty)
    else $error("result item appeared without an input item");

  // a waiting item is not lost while stalled
  a_hold_valid: assert property (@(posedge clk) disable iff (rst)
    !empty && !pop |=> !empty)
    else $error("waiting result item dropped");

  // a stalled item keeps its payload
  a_hold_data: assert property (@(posedge clk) disable iff (rst)
    !empty && !pop |=> $stable(result_kind) && $stable(status)
                      && $stable(sample) && $stable(last))
    else $error("stalled result payload changed");

endmodule

bind wav_pcm16_mono_stream_parser_unit wps_checker u_checker (
  .clk         (clk),
  .rst         (rst),
  .push        (push),
  .full        (full),
  .empty       (empty),
  .pop         (pop),
  .result_kind (result_kind),
  .status      (status),
  .sample      (sample),
  .last        (last)
);
